>>> hw/rtl/grw_pkg.sv
// Shared types and constants for the graph reachability walker.
// Used by grw_store, graph_reachability_walker_core and grw_checker.
package grw_pkg;

  localparam int NODES_DEF  = 64;
  localparam int DEGREE_DEF = 16;
  localparam int NODE_FW    = 6;   // width of a node field on the ports
  localparam int MAX_OUT    = 64;  // results per input word at most
  localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } grw_cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } grw_status_e;

  typedef struct packed {
    logic cnt_we;
    logic cnt_re;
    logic tgt_we;
    logic tgt_re;
  } grw_store_ctl_t;

endpackage

>>> hw/rtl/grw_store.sv
// Edge storage: per-node edge counts and the edge target table.
// Both are single-port-write memories with registered reads; depends on grw_pkg.
module grw_store import grw_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int DEGREE = DEGREE_DEF,
  localparam int NW = $clog2(NODES),
  localparam int CW = $clog2(DEGREE + 1),
  localparam int AW = $clog2(NODES * DEGREE)
) (
  input  logic                clk_i,
  input  grw_store_ctl_t      ctl_i,
  input  logic [NW-1:0]       cnt_waddr_i,
  input  logic [CW-1:0]       cnt_wdata_i,
  input  logic [NW-1:0]       cnt_raddr_i,
  output logic [CW-1:0]       cnt_rdata_o,
  input  logic [NW-1:0]       tgt_wnode_i,
  input  logic [CW-1:0]       tgt_wslot_i,
  input  logic [NODE_FW-1:0]  tgt_wdata_i,
  input  logic [NW-1:0]       tgt_rnode_i,
  input  logic [CW-1:0]       tgt_rslot_i,
  output logic [NODE_FW-1:0]  tgt_rdata_o
);

  logic [CW-1:0]      cnt_mem [NODES];
  logic [NODE_FW-1:0] tgt_mem [NODES * DEGREE];
  logic [AW-1:0]      tgt_waddr;
  logic [AW-1:0]      tgt_raddr;

  // Row-major layout: each node owns DEGREE consecutive slots.
  assign tgt_waddr = AW'(tgt_wnode_i) * AW'(DEGREE) + AW'(tgt_wslot_i);
  assign tgt_raddr = AW'(tgt_rnode_i) * AW'(DEGREE) + AW'(tgt_rslot_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_we) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    if (ctl_i.cnt_re) begin
      cnt_rdata_o <= cnt_mem[cnt_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata_i;
    end
    if (ctl_i.tgt_re) begin
      tgt_rdata_o <= tgt_mem[tgt_raddr];
    end
  end

endmodule

>>> hw/rtl/graph_reachability_walker_core.sv
// Channel  Dir  Word contents (lowest bit first)
// s_axis   in   tdata: command[1:0], from_node[7:2], to_node[13:8]
// m_axis   out  tdata: status[1:0], node[7:2]; tlast: last
//
// Top level of the graph reachability walker; depends on grw_pkg and grw_store.
// Add edge scans the stored edges of its node for a duplicate before it adds one; a query
// reads the edge entries of each node it enters and returns through the stack. All memory
// traffic goes through one read port each. The input is taken only in the idle state. A
// full output register stalls the sequencer in place. Reset clears control state; memories
// need no clearing.
module graph_reachability_walker_core import grw_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int DEGREE = DEGREE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // command[1:0], from_node[7:2], to_node[13:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // status[1:0], node[7:2]
  output logic        m_axis_tlast_o
);

  localparam int NW   = $clog2(NODES);
  localparam int NCW  = $clog2(NODES + 1);
  localparam int CW   = $clog2(DEGREE + 1);
  localparam int FW   = NW + CW;
  localparam int CMPW = NCW + NODE_FW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_EDGE,
    S_SCAN,
    S_CMP,
    S_ADD,
    S_QSTART,
    S_WCNT,
    S_WEDGE,
    S_WPOP,
    S_WTGT,
    S_WEND
  } state_e;

  state_e               state_q, state_d;
  grw_cmd_e             cmd_d;
  logic [NODE_FW-1:0]   from_q, from_d;
  logic [NODE_FW-1:0]   to_q, to_d;
  logic [NCW-1:0]       node_count_q, node_count_d;
  logic [NCW-1:0]       sp_q, sp_d;
  logic [NW-1:0]        cur_node_q, cur_node_d;
  logic [CW-1:0]        cur_slot_q, cur_slot_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic                 dup_q, dup_d;
  logic [OUT_CNT_W-1:0] emit_cnt_q, emit_cnt_d;
  logic [NODES-1:0]     visited_q, visited_d;
  grw_status_e          pend_status_q, pend_status_d;
  logic [NODE_FW-1:0]   pend_node_q, pend_node_d;
  logic                 out_valid_q, out_valid_d;
  grw_status_e          out_status_q, out_status_d;
  logic [NODE_FW-1:0]   out_node_q, out_node_d;
  logic                 out_last_q, out_last_d;

  grw_store_ctl_t       st_ctl;
  logic [NW-1:0]        cnt_waddr, cnt_raddr;
  logic [CW-1:0]        cnt_wdata, cnt_rdata;
  logic [NW-1:0]        tgt_wnode, tgt_rnode;
  logic [CW-1:0]        tgt_wslot, tgt_rslot;
  logic [NODE_FW-1:0]   tgt_rdata;

  // The top frame of the walk lives in cur_node_q/cur_slot_q; frames below it
  // are kept here, entry k holding level k.
  logic [FW-1:0]        stk_mem [NODES];
  logic [FW-1:0]        stk_rdata;
  logic                 stk_we, stk_re;
  logic [NW-1:0]        stk_waddr, stk_raddr;
  logic [FW-1:0]        stk_wdata;

  logic                 out_free;
  logic                 from_bad, tgt_bad;
  logic [NW-1:0]        from_idx, tgt_idx;

  grw_store #(
    .NODES  (NODES),
    .DEGREE (DEGREE)
  ) u_store (
    .clk_i       (clk_i),
    .ctl_i       (st_ctl),
    .cnt_waddr_i (cnt_waddr),
    .cnt_wdata_i (cnt_wdata),
    .cnt_raddr_i (cnt_raddr),
    .cnt_rdata_o (cnt_rdata),
    .tgt_wnode_i (tgt_wnode),
    .tgt_wslot_i (tgt_wslot),
    .tgt_wdata_i (to_q),
    .tgt_rnode_i (tgt_rnode),
    .tgt_rslot_i (tgt_rslot),
    .tgt_rdata_o (tgt_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign from_bad = CMPW'(from_q) >= CMPW'(node_count_q);
  assign tgt_bad  = CMPW'(tgt_rdata) >= CMPW'(node_count_q);
  assign from_idx = NW'(from_q);
  assign tgt_idx  = NW'(tgt_rdata);

  always_comb begin
    state_d       = state_q;
    cmd_d         = grw_cmd_e'(s_axis_tdata_i[1:0]);
    from_d        = from_q;
    to_d          = to_q;
    node_count_d  = node_count_q;
    sp_d          = sp_q;
    cur_node_d    = cur_node_q;
    cur_slot_d    = cur_slot_q;
    scan_d        = scan_q;
    dup_d         = dup_q;
    emit_cnt_d    = emit_cnt_q;
    visited_d     = visited_q;
    pend_status_d = pend_status_q;
    pend_node_d   = pend_node_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_status_d  = out_status_q;
    out_node_d    = out_node_q;
    out_last_d    = out_last_q;
    st_ctl        = '0;
    cnt_waddr     = from_idx;
    cnt_wdata     = '0;
    cnt_raddr     = from_idx;
    tgt_wnode     = from_idx;
    tgt_wslot     = cnt_rdata;
    tgt_rnode     = from_idx;
    tgt_rslot     = scan_q;
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_waddr     = NW'(sp_q - NCW'(1));
    stk_raddr     = NW'(sp_q - NCW'(2));
    stk_wdata     = {cur_node_q, cur_slot_q};

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          from_d = s_axis_tdata_i[7:2];
          to_d   = s_axis_tdata_i[13:8];
          unique case (cmd_d)
            CMD_ALLOC: state_d = S_ALLOC;
            CMD_EDGE:  state_d = S_EDGE;
            CMD_QUERY: state_d = S_QSTART;
            CMD_NOP:   state_d = S_IDLE;
          endcase
        end
      end

      S_ALLOC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (node_count_q >= NCW'(NODES)) begin
            out_status_d = ST_FULL;
            out_node_d   = '0;
          end else begin
            st_ctl.cnt_we = 1'b1;
            cnt_waddr     = NW'(node_count_q);
            out_status_d  = ST_OK;
            out_node_d    = NODE_FW'(node_count_q);
            node_count_d  = node_count_q + NCW'(1);
          end
          state_d = S_IDLE;
        end
      end

      S_EDGE: begin
        if (from_bad) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_last_d   = 1'b1;
            out_status_d = ST_INVALID;
            out_node_d   = '0;
            state_d      = S_IDLE;
          end
        end else begin
          st_ctl.cnt_re = 1'b1;
          scan_d        = '0;
          dup_d         = 1'b0;
          state_d       = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_q >= cnt_rdata) begin
          state_d = S_ADD;
        end else begin
          st_ctl.tgt_re = 1'b1;
          state_d       = S_CMP;
        end
      end

      S_CMP: begin
        if (tgt_rdata == to_q) begin
          dup_d   = 1'b1;
          state_d = S_ADD;
        end else begin
          scan_d  = scan_q + CW'(1);
          state_d = S_SCAN;
        end
      end

      S_ADD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_node_d  = '0;
          if (dup_q) begin
            out_status_d = ST_DUP;
          end else if (cnt_rdata >= CW'(DEGREE)) begin
            out_status_d = ST_FULL;
          end else begin
            st_ctl.tgt_we = 1'b1;
            st_ctl.cnt_we = 1'b1;
            cnt_wdata     = cnt_rdata + CW'(1);
            out_status_d  = ST_OK;
          end
          state_d = S_IDLE;
        end
      end

      S_QSTART: begin
        if (from_bad) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_last_d   = 1'b1;
            out_status_d = ST_INVALID;
            out_node_d   = from_q;
            state_d      = S_IDLE;
          end
        end else begin
          // The start node is held back until it is known whether it is last.
          visited_d[from_idx] = 1'b1;
          pend_status_d       = ST_OK;
          pend_node_d         = from_q;
          emit_cnt_d          = OUT_CNT_W'(1);
          cur_node_d          = from_idx;
          cur_slot_d          = '0;
          sp_d                = NCW'(1);
          state_d             = S_WCNT;
        end
      end

      S_WCNT: begin
        st_ctl.cnt_re = 1'b1;
        cnt_raddr     = cur_node_q;
        state_d       = S_WEDGE;
      end

      S_WEDGE: begin
        if (cur_slot_q >= cnt_rdata) begin
          if (sp_q == NCW'(1)) begin
            sp_d    = '0;
            state_d = S_WEND;
          end else begin
            stk_re  = 1'b1;
            sp_d    = sp_q - NCW'(1);
            state_d = S_WPOP;
          end
        end else begin
          st_ctl.tgt_re = 1'b1;
          tgt_rnode     = cur_node_q;
          tgt_rslot     = cur_slot_q;
          cur_slot_d    = cur_slot_q + CW'(1);
          state_d       = S_WTGT;
        end
      end

      S_WPOP: begin
        {cur_node_d, cur_slot_d} = stk_rdata;
        state_d                  = S_WCNT;
      end

      S_WTGT: begin
        if (tgt_bad) begin
          if (out_free) begin
            out_valid_d   = 1'b1;
            out_last_d    = 1'b0;
            out_status_d  = pend_status_q;
            out_node_d    = pend_node_q;
            pend_status_d = ST_INVALID;
            pend_node_d   = tgt_rdata;
            emit_cnt_d    = emit_cnt_q + OUT_CNT_W'(1);
            state_d       = S_WEND;
          end
        end else if (visited_q[tgt_idx]) begin
          state_d = S_WEDGE;
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_last_d           = 1'b0;
          out_status_d         = pend_status_q;
          out_node_d           = pend_node_q;
          pend_status_d        = ST_OK;
          pend_node_d          = tgt_rdata;
          visited_d[tgt_idx]   = 1'b1;
          stk_we               = 1'b1;
          cur_node_d           = tgt_idx;
          cur_slot_d           = '0;
          sp_d                 = sp_q + NCW'(1);
          emit_cnt_d           = emit_cnt_q + OUT_CNT_W'(1);
          // Once the result limit is reached nothing more can be delivered.
          if (emit_cnt_q == OUT_CNT_W'(MAX_OUT - 1)) begin
            state_d = S_WEND;
          end else begin
            state_d = S_WCNT;
          end
        end
      end

      S_WEND: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_status_d = pend_status_q;
          out_node_d   = pend_node_q;
          visited_d    = '0;
          sp_d         = '0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      from_q        <= '0;
      to_q          <= '0;
      node_count_q  <= '0;
      sp_q          <= '0;
      cur_node_q    <= '0;
      cur_slot_q    <= '0;
      scan_q        <= '0;
      dup_q         <= 1'b0;
      emit_cnt_q    <= '0;
      visited_q     <= '0;
      pend_status_q <= ST_OK;
      pend_node_q   <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_OK;
      out_node_q    <= '0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      from_q        <= from_d;
      to_q          <= to_d;
      node_count_q  <= node_count_d;
      sp_q          <= sp_d;
      cur_node_q    <= cur_node_d;
      cur_slot_q    <= cur_slot_d;
      scan_q        <= scan_d;
      dup_q         <= dup_d;
      emit_cnt_q    <= emit_cnt_d;
      visited_q     <= visited_d;
      pend_status_q <= pend_status_d;
      pend_node_q   <= pend_node_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_node_q    <= out_node_d;
      out_last_q    <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_node_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> hw/rtl/grw_checker.sv
// Port-level checks for graph_reachability_walker_core, attached by bind.
// Depends on grw_pkg for command and status codes.
module grw_checker import grw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // A result word waiting on a stalled output does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // Any real command leaves the block busy in the cycle after it is taken.
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] != CMD_NOP |=>
      !s_axis_tready_o)
    else $error("input taken again right after a command");

  // Every error or refusal ends the results of its command.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK |-> m_axis_tlast_o)
    else $error("non-ok status without last");

  // When the block is idle, only the final word of a command can be pending.
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("idle while a walk result is still open");

endmodule

bind graph_reachability_walker_core grw_checker u_grw_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for graph_reachability_walker_core.
// Depends on grw_pkg and the RTL; a built-in graph model predicts each untyped word,
// first for a directed table and then for random command sequences under varied idling.
module tb;
  import grw_pkg::*;

  localparam int NODES        = NODES_DEF;
  localparam int DEGREE       = DEGREE_DEF;
  localparam int PHASE_ITEMS  = 96;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 3 * 500 * (4 * NODES * DEGREE + MAX_OUT * 32 + 64);

  typedef struct {
    grw_status_e status;
    logic [5:0]  node;
    logic        last;
  } walk_word_t;

  typedef struct {
    grw_cmd_e    cmd;
    logic [5:0]  src;
    logic [5:0]  dst;
    bit          typed;
    grw_status_e t_status;
    logic [5:0]  t_node;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;   // command[1:0], from_node[7:2], to_node[13:8]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;         // status[1:0], node[7:2]
  logic        m_axis_tlast_o;

  // Graph model state.
  int         node_cnt;
  int         edge_cnt [NODES];
  logic [5:0] edge_tgt [NODES][DEGREE];

  walk_word_t step_words [$];
  walk_word_t due_words [$];

  int mismatches     = 0;
  int items_taken    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;

  stim_row_t dir_rows [24] = '{
    '{CMD_QUERY, 6'd0,  6'd0,  1'b1, ST_INVALID, 6'd0},
    '{CMD_EDGE,  6'd5,  6'd3,  1'b1, ST_INVALID, 6'd0},
    '{CMD_NOP,   6'd0,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_ALLOC, 6'd0,  6'd0,  1'b1, ST_OK,      6'd0},
    '{CMD_ALLOC, 6'd63, 6'd63, 1'b1, ST_OK,      6'd1},
    '{CMD_ALLOC, 6'd21, 6'd42, 1'b1, ST_OK,      6'd2},
    '{CMD_EDGE,  6'd0,  6'd1,  1'b1, ST_OK,      6'd0},
    '{CMD_EDGE,  6'd0,  6'd1,  1'b1, ST_DUP,     6'd0},
    '{CMD_EDGE,  6'd1,  6'd2,  1'b0, ST_OK,      6'd0},
    '{CMD_EDGE,  6'd2,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_EDGE,  6'd0,  6'd2,  1'b0, ST_OK,      6'd0},
    '{CMD_QUERY, 6'd0,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_QUERY, 6'd2,  6'd63, 1'b0, ST_OK,      6'd0},
    '{CMD_EDGE,  6'd2,  6'd63, 1'b0, ST_OK,      6'd0},
    '{CMD_QUERY, 6'd1,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_QUERY, 6'd63, 6'd0,  1'b1, ST_INVALID, 6'd63},
    '{CMD_QUERY, 6'd3,  6'd21, 1'b1, ST_INVALID, 6'd3},
    '{CMD_EDGE,  6'd63, 6'd63, 1'b1, ST_INVALID, 6'd0},
    '{CMD_EDGE,  6'd0,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_NOP,   6'd63, 6'd63, 1'b0, ST_OK,      6'd0},
    '{CMD_ALLOC, 6'd42, 6'd21, 1'b1, ST_OK,      6'd3},
    '{CMD_QUERY, 6'd0,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_EDGE,  6'd3,  6'd0,  1'b0, ST_OK,      6'd0},
    '{CMD_QUERY, 6'd3,  6'd0,  1'b0, ST_OK,      6'd0}
  };

  graph_reachability_walker_core #(
    .NODES (NODES),
    .DEGREE(DEGREE)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic void emit_word(grw_status_e st, logic [5:0] nd);
    walk_word_t w;
    w.status = st;
    w.node   = nd;
    w.last   = 1'b0;
    if (step_words.size() < MAX_OUT) step_words.push_back(w);
  endfunction

  // Depth-first preorder from one start node; an out-of-range target ends the walk.
  function automatic void walk_from(logic [5:0] start);
    int  sp;
    int  tnode;
    int  fr_node [NODES];
    int  fr_slot [NODES];
    bit  seen [NODES];
    bit  stop;
    if (start >= node_cnt) begin
      emit_word(ST_INVALID, start);
    end else begin
      foreach (seen[i]) seen[i] = 1'b0;
      seen[start] = 1'b1;
      emit_word(ST_OK, start);
      fr_node[0] = start;
      fr_slot[0] = 0;
      sp = 1;
      stop = 1'b0;
      while (sp > 0 && !stop) begin
        if (fr_slot[sp-1] >= edge_cnt[fr_node[sp-1]]) begin
          sp--;
        end else begin
          tnode = edge_tgt[fr_node[sp-1]][fr_slot[sp-1]];
          fr_slot[sp-1]++;
          if (tnode >= node_cnt) begin
            emit_word(ST_INVALID, 6'(tnode));
            stop = 1'b1;
          end else if (!seen[tnode]) begin
            seen[tnode] = 1'b1;
            emit_word(ST_OK, 6'(tnode));
            if (sp < NODES) begin
              fr_node[sp] = tnode;
              fr_slot[sp] = 0;
              sp++;
            end
          end
        end
      end
    end
  endfunction

  function automatic void graph_exec(grw_cmd_e cmd, logic [5:0] src, logic [5:0] dst);
    bit         dup;
    walk_word_t w;
    step_words.delete();
    case (cmd)
      CMD_ALLOC: begin
        if (node_cnt >= NODES) begin
          emit_word(ST_FULL, 6'd0);
        end else begin
          edge_cnt[node_cnt] = 0;
          emit_word(ST_OK, 6'(node_cnt));
          node_cnt++;
        end
      end
      CMD_EDGE: begin
        if (src >= node_cnt) begin
          emit_word(ST_INVALID, 6'd0);
        end else begin
          dup = 1'b0;
          for (int i = 0; i < edge_cnt[src]; i++) begin
            if (edge_tgt[src][i] == dst) dup = 1'b1;
          end
          if (dup) begin
            emit_word(ST_DUP, 6'd0);
          end else if (edge_cnt[src] >= DEGREE) begin
            emit_word(ST_FULL, 6'd0);
          end else begin
            edge_tgt[src][edge_cnt[src]] = dst;
            edge_cnt[src]++;
            emit_word(ST_OK, 6'd0);
          end
        end
      end
      CMD_QUERY: walk_from(src);
      default: ;
    endcase
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void check_word(logic [1:0] st, logic [5:0] nd, logic lst);
    walk_word_t w;
    if (due_words.size() == 0) begin
      note_mismatch($sformatf("unexpected word: status %0d node %0d last %0b", st, nd, lst));
    end else begin
      w = due_words.pop_front();
      if (st !== w.status || nd !== w.node || lst !== w.last)
        note_mismatch($sformatf(
          "word mismatch: expected status %0d node %0d last %0b, got status %0d node %0d last %0b",
          w.status, w.node, w.last, st, nd, lst));
    end
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o === 1'b1 && m_axis_tready_i)
      check_word(m_axis_tdata_o[1:0], m_axis_tdata_o[7:2], m_axis_tlast_o);
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Picks an allocated node most of the time, otherwise any index.
  function automatic logic [5:0] pick_node(int valid_pct);
    if (node_cnt > 0 && $urandom_range(99) < valid_pct) return 6'($urandom_range(node_cnt - 1));
    return 6'($urandom_range(63));
  endfunction

  // Each call starts at the falling edge right after the previous word was taken,
  // so a back-to-back word keeps tvalid high without a drop.
  task automatic send_word(input grw_cmd_e cmd, input logic [5:0] src, input logic [5:0] dst,
                           input bit typed, input grw_status_e t_status,
                           input logic [5:0] t_node);
    int         gap;
    bit         taken;
    walk_word_t w;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, dst, src, cmd};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_axis_tready_o;
    end
    graph_exec(cmd, src, dst);
    if (typed) begin
      w.status = t_status;
      w.node   = t_node;
      w.last   = 1'b1;
      due_words.push_back(w);
    end else begin
      foreach (step_words[i]) due_words.push_back(step_words[i]);
    end
    if (cmd != CMD_NOP) items_taken++;
  endtask

  task automatic send_plain(input grw_cmd_e cmd, input logic [5:0] src, input logic [5:0] dst);
    send_word(cmd, src, dst, 1'b0, ST_OK, 6'd0);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed command runs on allocated nodes, with some noise mixed in.
  task automatic random_run(input int count);
    int target;
    int pick;
    int n;
    logic [5:0] hub;
    target = items_taken + count;
    while (items_taken < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        n = $urandom_range(1, 6);
        repeat (n) send_plain(CMD_ALLOC, 6'($urandom_range(63)), 6'($urandom_range(63)));
      end else if (pick < 55) begin
        n = $urandom_range(1, 6);
        repeat (n) send_plain(CMD_EDGE, pick_node(92), pick_node(85));
      end else if (pick < 60) begin
        // Send more edges to one list than it can hold.
        hub = pick_node(100);
        repeat (DEGREE + 2) send_plain(CMD_EDGE, hub, pick_node(95));
      end else if (pick < 88) begin
        send_plain(CMD_QUERY, pick_node(92), 6'($urandom_range(63)));
      end else if (pick < 94) begin
        send_plain(CMD_NOP, 6'($urandom_range(63)), 6'($urandom_range(63)));
      end else begin
        send_plain(grw_cmd_e'($urandom_range(2)), 6'($urandom_range(63)),
                   6'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    node_cnt = 0;
    foreach (edge_cnt[i]) edge_cnt[i] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].src, dir_rows[i].dst, dir_rows[i].typed,
                dir_rows[i].t_status, dir_rows[i].t_node);
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      random_run(PHASE_ITEMS);
      hold_until_drained();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/grw_pkg.sv
hw/rtl/grw_store.sv
hw/rtl/graph_reachability_walker_core.sv
hw/rtl/grw_checker.sv
dv/tb.sv
